[rtl/kirkwood_inverse_radius_core_assert.svh]
// Assertion macros for the inverse Kirkwood radius core.
`ifndef KIRKWOOD_INVERSE_RADIUS_CORE_ASSERT_SVH
`define KIRKWOOD_INVERSE_RADIUS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KIR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KIR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KIR_ASSERT(label, clk, rst_n, prop, msg)
`define KIR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[rtl/kir_pkg.sv]
// Shared constants and command/status types of the inverse Kirkwood radius core.
`default_nettype none
package kir_pkg;
  localparam int MAX_PARTICLES = 256;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam int NN_W = 2 * CNT_W;
  localparam int DIV_W = 64;
  localparam int DVS_W = 34;
  localparam int S_W = 66;
  localparam int ROOT_W = 33;
  localparam int RSUM_W = 48;
  localparam int PSUM_W = 64;
  localparam int RAD_TERM_W = 41;
  localparam int PAIR_TERM_W = 42;

  localparam logic [RAD_TERM_W-1:0] RECIP_NUM = {1'b1, {(RAD_TERM_W-1){1'b0}}};
  localparam logic [PAIR_TERM_W-1:0] PAIR_NUM = {1'b1, {(PAIR_TERM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    DIV_RAD  = 2'd0,
    DIV_PAIR = 2'd1,
    DIV_FIN  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     rsum_acc;
    logic     pair_init;
    logic     pair_rd;
    logic     sq_en;
    logic [1:0] sq_axis;
    logic     sq_acc;
    logic     sqrt_start;
    logic     pair_acc;
    logic     pair_next;
    logic     fin_start;
    logic     out_load;
    logic     clear;
  } cmd_t;

  typedef struct packed {
    logic in_need_div;
    logic in_last;
    logic last_q;
    logic div_busy;
    logic div_done;
    logic sqrt_busy;
    logic sqrt_done;
    logic root_zero;
    logic pair_more;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

[rtl/kir_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module kir_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [kir_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [kir_pkg::DVS_W-1:0] divisor_i,
  output logic [kir_pkg::DIV_W-1:0]      quotient_o,
  output logic                           busy_o,
  output logic                           done_o
);
  localparam int CW = $clog2(kir_pkg::DIV_W);

  logic                      busy_q, done_q;
  logic [CW-1:0]             cnt_q;
  logic [kir_pkg::DIV_W-1:0] q_q;
  logic [kir_pkg::DVS_W-1:0] dvs_q;
  logic [kir_pkg::DVS_W:0]   rem_q, rem_sh, rem_d;
  logic                      ge;

  always_comb begin
    rem_sh = {rem_q[kir_pkg::DVS_W-1:0], q_q[kir_pkg::DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(kir_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= {q_q[kir_pkg::DIV_W-2:0], ge};
    end
  end

  assign quotient_o = q_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;
endmodule
`default_nettype wire

[rtl/kir_sqrt.sv]
// Integer square root, two radicand bits per cycle.
`default_nettype none
module kir_sqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [kir_pkg::S_W-1:0]  value_i,
  output logic [kir_pkg::ROOT_W-1:0]    root_o,
  output logic                          busy_o,
  output logic                          done_o
);
  localparam int CW = $clog2(kir_pkg::ROOT_W);
  localparam int RW = kir_pkg::ROOT_W + 3;

  logic                       busy_q, done_q;
  logic [CW-1:0]              cnt_q;
  logic [kir_pkg::S_W-1:0]    s_q;
  logic [kir_pkg::ROOT_W-1:0] root_q;
  logic [RW-1:0]              rem_q, rem_sh, trial, rem_d;
  logic                       ge;

  always_comb begin
    rem_sh = {rem_q[RW-3:0], s_q[kir_pkg::S_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(kir_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q    <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      s_q    <= {s_q[kir_pkg::S_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[kir_pkg::ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign busy_o = busy_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

[rtl/kir_dp.sv]
// Datapath: position stores, accumulators, squaring, root and divider units.
`default_nettype none
module kir_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire kir_pkg::cmd_t cmd_i,
  output kir_pkg::sts_t      sts_o,
  input  wire logic [31:0]   pos_x_i,
  input  wire logic [31:0]   pos_y_i,
  input  wire logic [31:0]   pos_z_i,
  input  wire logic [31:0]   hradius_i,
  input  wire logic          last_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [31:0]        rk_inverse_o,
  output logic               degenerate_o,
  output logic               saturated_o
);
  localparam int AW = kir_pkg::ADDR_W;
  localparam int CW = kir_pkg::CNT_W;

  logic [31:0] mem_x [kir_pkg::MAX_PARTICLES];
  logic [31:0] mem_y [kir_pkg::MAX_PARTICLES];
  logic [31:0] mem_z [kir_pkg::MAX_PARTICLES];
  logic [31:0] xa_q, xb_q, ya_q, yb_q, za_q, zb_q;

  logic [CW-1:0]              count_q, i_q, j_q;
  logic [kir_pkg::RSUM_W-1:0] rsum_q;
  logic [kir_pkg::PSUM_W-1:0] psum_q;
  logic                       deg_q, sat_q, last_q, full;
  logic [63:0]                sq_q;
  logic [kir_pkg::S_W-1:0]    s_q;
  logic                       out_valid_q, deg_out_q, sat_out_q;
  logic [31:0]                rk_q;

  logic [32:0] dx, dy, dz, dsel;
  logic [31:0] absv;

  logic [kir_pkg::RAD_TERM_W-1:0] rad_term;
  logic [kir_pkg::RSUM_W:0]       rs_sum;
  logic [kir_pkg::PAIR_TERM_W-1:0] p_term;
  logic [kir_pkg::PSUM_W:0]       p_sum, t_sum;
  logic [kir_pkg::PSUM_W-1:0]     total;
  logic [kir_pkg::NN_W-1:0]       nn;

  logic [kir_pkg::DIV_W-1:0]  div_dividend, div_q;
  logic [kir_pkg::DVS_W-1:0]  div_divisor;
  logic                       div_busy, div_done;
  logic [kir_pkg::ROOT_W-1:0] root;
  logic                       sqrt_busy, sqrt_done;
  logic                       store_now, rad_zero_now;

  assign full         = count_q == CW'(kir_pkg::MAX_PARTICLES);
  assign store_now    = cmd_i.load && !full;
  assign rad_zero_now = store_now && (hradius_i == 32'd0);

  // Absolute coordinate difference of the selected axis.
  always_comb begin
    dx = {xa_q[31], xa_q} - {xb_q[31], xb_q};
    dy = {ya_q[31], ya_q} - {yb_q[31], yb_q};
    dz = {za_q[31], za_q} - {zb_q[31], zb_q};
    case (cmd_i.sq_axis)
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
    absv = dsel[32] ? 32'(~dsel + 33'd1) : dsel[31:0];
  end

  always_comb begin
    rad_term = rad_zero_now ? kir_pkg::RECIP_NUM : div_q[kir_pkg::RAD_TERM_W-1:0];
    rs_sum   = {1'b0, rsum_q} + {{(kir_pkg::RSUM_W + 1 - kir_pkg::RAD_TERM_W){1'b0}}, rad_term};
    p_term   = (root == '0) ? kir_pkg::PAIR_NUM : div_q[kir_pkg::PAIR_TERM_W-1:0];
    p_sum    = {1'b0, psum_q} + {{(kir_pkg::PSUM_W + 1 - kir_pkg::PAIR_TERM_W){1'b0}}, p_term};
    t_sum    = {1'b0, psum_q} + {{(kir_pkg::PSUM_W + 1 - kir_pkg::RSUM_W){1'b0}}, rsum_q};
    total    = t_sum[kir_pkg::PSUM_W] ? '1 : t_sum[kir_pkg::PSUM_W-1:0];
    nn       = kir_pkg::NN_W'(count_q) * kir_pkg::NN_W'(count_q);
  end

  always_comb begin
    case (cmd_i.div_sel)
      kir_pkg::DIV_RAD: begin
        div_dividend = {{(kir_pkg::DIV_W - kir_pkg::RAD_TERM_W){1'b0}}, kir_pkg::RECIP_NUM};
        div_divisor  = {{(kir_pkg::DVS_W - 32){1'b0}}, hradius_i};
      end
      kir_pkg::DIV_PAIR: begin
        div_dividend = {{(kir_pkg::DIV_W - kir_pkg::PAIR_TERM_W){1'b0}}, kir_pkg::PAIR_NUM};
        div_divisor  = {{(kir_pkg::DVS_W - kir_pkg::ROOT_W){1'b0}}, root};
      end
      default: begin
        div_dividend = total;
        div_divisor  = {{(kir_pkg::DVS_W - kir_pkg::NN_W){1'b0}}, nn};
      end
    endcase
  end

  kir_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_q),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  kir_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (s_q),
    .root_o  (root),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done)
  );

  always_ff @(posedge clk_i) begin
    if (store_now) begin
      mem_x[count_q[AW-1:0]] <= pos_x_i;
      mem_y[count_q[AW-1:0]] <= pos_y_i;
      mem_z[count_q[AW-1:0]] <= pos_z_i;
    end
    if (cmd_i.pair_rd) begin
      xa_q <= mem_x[i_q[AW-1:0]];
      xb_q <= mem_x[j_q[AW-1:0]];
      ya_q <= mem_y[i_q[AW-1:0]];
      yb_q <= mem_y[j_q[AW-1:0]];
      za_q <= mem_z[i_q[AW-1:0]];
      zb_q <= mem_z[j_q[AW-1:0]];
    end
    if (cmd_i.sq_en) begin
      sq_q <= absv * absv;
    end
    if (cmd_i.pair_rd) begin
      s_q <= '0;
    end else if (cmd_i.sq_acc) begin
      s_q <= s_q + {2'b00, sq_q};
    end
    if (cmd_i.out_load) begin
      rk_q      <= (div_q[63:32] != 32'd0) ? '1 : div_q[31:0];
      deg_out_q <= deg_q;
      sat_out_q <= sat_q || (div_q[63:32] != 32'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsum_q      <= '0;
      psum_q      <= '0;
      deg_q       <= 1'b0;
      sat_q       <= 1'b0;
      last_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        last_q <= last_i;
      end
      if (store_now) begin
        count_q <= count_q + 1'b1;
      end
      if (rad_zero_now || cmd_i.rsum_acc) begin
        if (rs_sum[kir_pkg::RSUM_W]) begin
          rsum_q <= '1;
          sat_q  <= 1'b1;
        end else begin
          rsum_q <= rs_sum[kir_pkg::RSUM_W-1:0];
        end
      end
      if (rad_zero_now) begin
        deg_q <= 1'b1;
      end
      if (cmd_i.pair_init) begin
        i_q <= '0;
        j_q <= CW'(1);
      end else if (cmd_i.pair_next) begin
        if ((j_q + 1'b1) < count_q) begin
          j_q <= j_q + 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
          j_q <= i_q + CW'(2);
        end
      end
      if (cmd_i.pair_acc) begin
        if (p_sum[kir_pkg::PSUM_W]) begin
          psum_q <= '1;
          sat_q  <= 1'b1;
        end else begin
          psum_q <= p_sum[kir_pkg::PSUM_W-1:0];
        end
        if (root == '0) begin
          deg_q <= 1'b1;
        end
      end
      if (cmd_i.fin_start && t_sum[kir_pkg::PSUM_W]) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        rsum_q  <= '0;
        psum_q  <= '0;
        deg_q   <= 1'b0;
        sat_q   <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.in_need_div = !full && (hradius_i != 32'd0);
    sts_o.in_last     = last_i;
    sts_o.last_q      = last_q;
    sts_o.div_busy    = div_busy;
    sts_o.div_done    = div_done;
    sts_o.sqrt_busy   = sqrt_busy;
    sts_o.sqrt_done   = sqrt_done;
    sts_o.root_zero   = root == '0;
    sts_o.pair_more   = j_q < count_q;
    sts_o.out_busy    = out_valid_q && out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign rk_inverse_o = rk_q;
  assign degenerate_o = deg_out_q;
  assign saturated_o  = sat_out_q;
endmodule
`default_nettype wire

[rtl/kir_ctrl.sv]
// Controller: sequences loading, the pairwise sweep and the final division.
`default_nettype none
module kir_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire kir_pkg::sts_t sts_i,
  output kir_pkg::cmd_t      cmd_o
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RWAIT  = 10'b0000000010,
    S_PINIT  = 10'b0000000100,
    S_PCHK   = 10'b0000001000,
    S_PSQ    = 10'b0000010000,
    S_PSQRT  = 10'b0000100000,
    S_PDWAIT = 10'b0001000000,
    S_FSTART = 10'b0010000000,
    S_FWAIT  = 10'b0100000000,
    S_FOUT   = 10'b1000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] sq_cnt_q, sq_cnt_d;

  always_comb begin
    state_d  = state_q;
    sq_cnt_d = sq_cnt_q;
    cmd_o    = '0;
    cmd_o.div_sel = kir_pkg::DIV_RAD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_need_div) begin
            cmd_o.div_start = 1'b1;
            state_d = S_RWAIT;
          end else if (sts_i.in_last) begin
            state_d = S_PINIT;
          end
        end
      end
      S_RWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.rsum_acc = 1'b1;
          state_d = sts_i.last_q ? S_PINIT : S_IDLE;
        end
      end
      S_PINIT: begin
        cmd_o.pair_init = 1'b1;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (sts_i.pair_more) begin
          cmd_o.pair_rd = 1'b1;
          sq_cnt_d = '0;
          state_d = S_PSQ;
        end else begin
          state_d = S_FSTART;
        end
      end
      S_PSQ: begin
        // Square one axis per cycle; each square is added in the next cycle.
        cmd_o.sq_en   = sq_cnt_q < 3'd3;
        cmd_o.sq_axis = sq_cnt_q[1:0];
        cmd_o.sq_acc  = (sq_cnt_q != 3'd0) && (sq_cnt_q < 3'd4);
        sq_cnt_d = sq_cnt_q + 3'd1;
        if (sq_cnt_q == 3'd4) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = S_PSQRT;
        end
      end
      S_PSQRT: begin
        if (sts_i.sqrt_done) begin
          if (sts_i.root_zero) begin
            cmd_o.pair_acc  = 1'b1;
            cmd_o.pair_next = 1'b1;
            state_d = S_PCHK;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = kir_pkg::DIV_PAIR;
            state_d = S_PDWAIT;
          end
        end
      end
      S_PDWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.pair_acc  = 1'b1;
          cmd_o.pair_next = 1'b1;
          state_d = S_PCHK;
        end
      end
      S_FSTART: begin
        cmd_o.fin_start = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = kir_pkg::DIV_FIN;
        state_d = S_FWAIT;
      end
      S_FWAIT: begin
        if (sts_i.div_done) begin
          state_d = S_FOUT;
        end
      end
      S_FOUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sq_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      sq_cnt_q <= sq_cnt_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;
endmodule
`default_nettype wire

[rtl/kirkwood_inverse_radius_core.sv]
// Top level of the inverse Kirkwood hydrodynamic radius core.
// Input channel: one particle per item (pos_x/y/z signed Q16.16, hradius
// unsigned Q16.16, last). Output channel: one item per conformation with
// rk_inverse in unsigned Q8.24 plus degenerate and saturated flags.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Loading needs no division for an item with zero radius or when the store is
// full; otherwise the controller waits for the 64-step shared divider.
// After the last item, each of the N*(N-1)/2 pairs takes a two-port read,
// three squares, a 33-step root and, unless the root is zero, a 64-step divide.
// The final divide by N*N follows the pair sweep and precedes the result item.
// Input stall stays high from the accepted item until the controller is back
// in idle. A finished result waits in the output register while the receiver
// stalls; the next conformation may load meanwhile, and only a second result
// waits for the first to be taken.
// Reset clears the count, accumulators, flags and the output valid; the
// position stores are not cleared and only entries written since are read.
`default_nettype none
`include "kirkwood_inverse_radius_core_assert.svh"
module kirkwood_inverse_radius_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] hradius_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      rk_inverse_o,
  output logic             degenerate_o,
  output logic             saturated_o
);
  kir_pkg::cmd_t cmd;
  kir_pkg::sts_t sts;

  kir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kir_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .hradius_i    (hradius_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rk_inverse_o (rk_inverse_o),
    .degenerate_o (degenerate_o),
    .saturated_o  (saturated_o)
  );

  `KIR_ASSERT(a_div_start_idle, clk_i, rst_ni, cmd.div_start |-> !sts.div_busy, "divider restarted while busy")
  `KIR_ASSERT(a_sqrt_start_idle, clk_i, rst_ni, cmd.sqrt_start |-> !sts.sqrt_busy, "root unit restarted while busy")
  `KIR_ASSERT(a_out_from_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd.out_load), "result without a load command")
endmodule
`default_nettype wire

[test/tb_kirkwood_inverse_radius_core.sv]
// Testbench for the inverse Kirkwood hydrodynamic radius core, checked against a scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module tb_kirkwood_inverse_radius_core;
  typedef struct {
    logic [31:0] rk;
    logic        deg;
    logic        sat;
  } radius_result_t;

  class kirkwood_board;
    logic [31:0]    px [kir_pkg::MAX_PARTICLES];
    logic [31:0]    py [kir_pkg::MAX_PARTICLES];
    logic [31:0]    pz [kir_pkg::MAX_PARTICLES];
    int unsigned    count;
    logic [47:0]    recip_sum;
    logic [63:0]    pair_total;
    logic           deg_seen;
    logic           sat_seen;
    radius_result_t pending[$];
    int unsigned    errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      count = 0;
      recip_sum = '0;
      pair_total = '0;
      deg_seen = 1'b0;
      sat_seen = 1'b0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function automatic logic [32:0] root66(logic [65:0] s);
      logic [32:0] r;
      logic [32:0] cand;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
        cand = r | (33'd1 << b);
        if ({33'd0, cand} * {33'd0, cand} <= s) r = cand;
      end
      return r;
    endfunction

    function automatic logic [65:0] sq_diff(logic [31:0] a, logic [31:0] b);
      logic signed [33:0] d;
      logic [32:0] m;
      d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
      m = d[33] ? 33'(-d) : d[32:0];
      return {33'd0, m} * {33'd0, m};
    endfunction

    function automatic logic [63:0] add_clamp(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) begin
        sat_seen = 1'b1;
        return '1;
      end
      return s[63:0];
    endfunction

    // Notes an accepted particle; a last item queues one expected result.
    function void note_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [31:0] r, logic l);
      logic [48:0] rs;
      logic [40:0] term;
      logic [65:0] s;
      logic [32:0] d;
      logic [63:0] tot;
      logic [63:0] res;
      logic [41:0] pterm;
      radius_result_t e;
      if (count < kir_pkg::MAX_PARTICLES) begin
        px[count] = x;
        py[count] = y;
        pz[count] = z;
        count++;
        if (r == 0) begin
          term = 41'd1 << 40;
          deg_seen = 1'b1;
        end else begin
          term = 41'((64'd1 << 40) / r);
        end
        rs = {1'b0, recip_sum} + term;
        if (rs[48]) begin
          recip_sum = '1;
          sat_seen = 1'b1;
        end else begin
          recip_sum = rs[47:0];
        end
      end
      if (!l) return;
      for (int i = 0; i < count; i++) begin
        for (int j = i + 1; j < count; j++) begin
          s = sq_diff(px[i], px[j]) + sq_diff(py[i], py[j]) + sq_diff(pz[i], pz[j]);
          d = root66(s);
          if (d == 0) begin
            pterm = 42'd1 << 41;
            deg_seen = 1'b1;
          end else begin
            pterm = 42'((64'd1 << 41) / d);
          end
          pair_total = add_clamp(pair_total, 64'(pterm));
        end
      end
      tot = add_clamp(pair_total, 64'(recip_sum));
      res = count ? tot / (64'(count) * 64'(count)) : '0;
      if (res > 64'hFFFF_FFFF) begin
        res = 64'hFFFF_FFFF;
        sat_seen = 1'b1;
      end
      e.rk = res[31:0];
      e.deg = deg_seen;
      e.sat = sat_seen;
      pending.push_back(e);
      clear();
    endfunction

    task check_result(logic [31:0] rk, logic deg, logic sat);
      radius_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result rk=%h", rk));
        return;
      end
      e = pending.pop_front();
      if (rk !== e.rk) report($sformatf("rk_inverse %h, expected %h", rk, e.rk));
      if (deg !== e.deg) report($sformatf("degenerate %b, expected %b", deg, e.deg));
      if (sat !== e.sat) report($sformatf("saturated %b, expected %b", sat, e.sat));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [31:0] pos_z_i = '0;
  logic [31:0] hradius_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] rk_inverse_o;
  logic        degenerate_o;
  logic        saturated_o;

  kirkwood_board board = new();
  bit            calm = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   sent = 0;
  logic [31:0]   prev_x = '0, prev_y = '0, prev_z = '0;

  kirkwood_inverse_radius_core u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("tb_kirkwood_inverse_radius_core NOT OK");
    $finish;
  end

  // Receiver stalls in random bursts.
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(rk_inverse_o, degenerate_o, saturated_o);
  end

  task send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                     logic [31:0] r, logic l);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    hradius_i <= r;
    last_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    board.note_particle(x, y, z, r, l);
    prev_x = x;
    prev_y = y;
    prev_z = z;
    sent++;
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] prev);
    case ($urandom_range(0, 5))
      0: return prev;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      3: return prev + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(1, 16);
      2: return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
      3: return $urandom_range(1, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single particles: radius of one LSB overflows the output, zero radius
    // is degenerate, the largest radius gives the smallest term.
    send_particle('0, '0, '0, 32'd1, 1'b1);
    send_particle('0, '0, '0, '0, 1'b1);
    send_particle(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // Farthest possible pair, then a coincident pair.
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1'b0);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1);
    send_particle(32'h0001_0000, 32'hFFFF_0000, '0, 32'h0002_0000, 1'b0);
    send_particle(32'h0001_0000, 32'hFFFF_0000, '0, 32'h0002_0000, 1'b1);
    // Neighbors one LSB apart on each axis.
    send_particle(32'd5, 32'd5, 32'd5, 32'h0000_8000, 1'b0);
    send_particle(32'd6, 32'd5, 32'd5, 32'h0000_8000, 1'b0);
    send_particle(32'd6, 32'd6, 32'd6, 32'h0000_8000, 1'b1);
    wait_drained();

    // Full store: tiny radii overflow the radius sum, and the items past
    // capacity are dropped, the second of them still closing the set.
    for (int k = 0; k < kir_pkg::MAX_PARTICLES + 2; k++)
      send_particle($urandom, $urandom, $urandom, (k % 2) ? 32'd1 : 32'd0,
                    k == kir_pkg::MAX_PARTICLES + 1);
    wait_drained();

    while (sent < 1500) begin
      if (sent > 1300) calm = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++)
        send_particle(pick_coord(prev_x), pick_coord(prev_y), pick_coord(prev_z),
                      pick_radius(), k == n - 1);
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb_kirkwood_inverse_radius_core OK");
    end else begin
      $display("tb_kirkwood_inverse_radius_core NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
